// ----- src/mrs_pkg.sv -----
// Shared constants and the CRC-16 byte update for the Modbus RTU slave.
// No dependencies; imported by the slave engine top level.
package mrs_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] EXC_FLAG     = 8'h80;
  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;

  localparam logic [7:0] FC_RD_COILS   = 8'h01;
  localparam logic [7:0] FC_READ_REGS  = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL = 8'h05;

  localparam logic [15:0] COIL_ON    = 16'hFF00;
  localparam logic [15:0] COIL_CLEAR = 16'h0000;

  localparam int REPLY_MAX = 9;

  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_FRAME_TIMEOUT = 1'b1;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Fold one byte into a reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ----- src/modbus_rtu_slave_engine.sv -----
// Byte item: accepted while idle, no result. Tick item that ends a frame of
// 4 bytes or more: the buffer memory is walked one byte a cycle, decoded
// (wrong address or CRC: no reply), the CRC runs over the reply body bytes
// (3..7) and is stored, then 5..9 result items go out, one a cycle while
// out_ready_i is high. Input is held off until the last result item is taken.
// Reset clears valid bits, length, idle count and coils; address 1, timeout 5.
// Modbus RTU slave engine: frame buffer memory, decode sequencer, reply path.
// Depends on mrs_pkg.
module modbus_rtu_slave_engine
  import mrs_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [3:0]  digital_inputs_i,
  input  logic [31:0] scan_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  output logic [3:0]  coil_outputs_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] MIN_WALK = CW'(6);

  typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_DECODE, ST_CRC, ST_EMIT} state_e;

  state_e        state_q;
  logic [7:0]    slave_addr_q;
  logic [15:0]   timeout_q;
  logic [CW-1:0] len_q, flen_q, cnt_q;
  logic [15:0]   idle_q;
  logic [3:0]    coil_q;
  logic [3:0]    din_q;
  logic [31:0]   scan_q;
  logic [15:0]   crc_q;
  logic [7:0]    hdr_q [6];
  logic [7:0]    fcs_lo_q, fcs_hi_q;
  logic [7:0]    rb_q [REPLY_MAX];
  logic [3:0]    n_q, k_q;

  // Frame buffer memory with per-entry valid bits.
  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    mem_rdata_q;
  logic [BUFFER_DEPTH-1:0] vld_q;
  logic          rvld_q;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign mem_we  = in_acc && (req_type_i == REQ_BYTE) && (len_q < CW'(BUFFER_DEPTH));
  assign mem_raddr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[len_q[AW-1:0]] <= rx_byte_i;
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[len_q[AW-1:0]] <= 1'b1;
      rvld_q <= vld_q[mem_raddr];
    end
  end

  // Walk bookkeeping.
  logic [CW-1:0] walk_n, j;
  logic [7:0]    rbyte;
  logic [15:0]   idle_inc;
  assign walk_n   = (flen_q >= MIN_WALK) ? flen_q : MIN_WALK;
  assign j        = cnt_q - CW'(1);
  assign rbyte    = rvld_q ? mem_rdata_q : 8'h00;
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  // Request decode and reply body construction.
  logic [7:0]  fc;
  logic [15:0] req_addr, req_qty;
  logic [16:0] span;
  logic [7:0]  bd [7];
  logic [3:0]  bn;
  logic [3:0]  coil_d;
  logic [7:0]  src8, mask8;
  logic [15:0] w0;
  logic        frame_ok;

  always_comb begin
    fc       = hdr_q[1];
    req_addr = {hdr_q[2], hdr_q[3]};
    req_qty  = {hdr_q[4], hdr_q[5]};
    span     = {1'b0, req_addr} + {1'b0, req_qty};
    src8     = {din_q, coil_q};
    mask8    = 8'((9'd1 << req_qty[3:0]) - 9'd1);
    w0       = (req_addr == 16'd0) ? scan_q[15:0] : scan_q[31:16];
    frame_ok = (hdr_q[0] == slave_addr_q) && ({fcs_hi_q, fcs_lo_q} == crc_q);
    coil_d   = coil_q;
    for (int i = 0; i < 7; i++) bd[i] = 8'h00;
    bd[0] = slave_addr_q;
    bd[1] = fc | EXC_FLAG;
    bd[2] = EXC_FUNCTION;
    bn    = 4'd3;
    case (fc)
      FC_RD_COILS: begin
        if (req_qty == 16'd0 || req_qty > 16'd8 || span > 17'd8) begin
          bd[2] = EXC_ADDRESS;
        end else begin
          bd[1] = fc;
          bd[2] = 8'h01;
          bd[3] = (src8 >> req_addr[2:0]) & mask8;
          bn    = 4'd4;
        end
      end
      FC_WRITE_COIL: begin
        if (req_addr > 16'd3) begin
          bd[2] = EXC_ADDRESS;
        end else if (req_qty != COIL_ON && req_qty != COIL_CLEAR) begin
          bd[2] = EXC_VALUE;
        end else begin
          coil_d[req_addr[1:0]] = (req_qty == COIL_ON);
          bd[1] = fc;
          bd[2] = hdr_q[2];
          bd[3] = hdr_q[3];
          bd[4] = hdr_q[4];
          bd[5] = hdr_q[5];
          bn    = 4'd6;
        end
      end
      FC_READ_REGS: begin
        if (req_qty == 16'd0 || req_qty > 16'd2 || span > 17'd2) begin
          bd[2] = EXC_ADDRESS;
        end else begin
          bd[1] = fc;
          bd[2] = {5'd0, req_qty[1:0], 1'b0};
          bd[3] = w0[15:8];
          bd[4] = w0[7:0];
          bd[5] = scan_q[31:24];
          bd[6] = scan_q[23:16];
          bn    = (req_qty == 16'd2) ? 4'd7 : 4'd5;
        end
      end
      default: begin
        bd[2] = EXC_FUNCTION;
      end
    endcase
  end

  logic [15:0] crc_next_walk, crc_next_body;
  assign crc_next_walk = crc_byte(crc_q, rbyte);
  assign crc_next_body = crc_byte(crc_q, rb_q[k_q]);

  // Sequencer: buffering, frame walk, decode, reply CRC and emission.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slave_addr_q <= 8'd1;
      timeout_q    <= 16'd5;
      len_q        <= '0;
      flen_q       <= '0;
      cnt_q        <= '0;
      idle_q       <= '0;
      coil_q       <= '0;
      n_q          <= '0;
      k_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SLAVE_ADDRESS: slave_addr_q <= cfg_wdata_i[7:0];
          CFG_FRAME_TIMEOUT: timeout_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_type_i == REQ_BYTE) begin
              if (mem_we) begin
                len_q  <= len_q + CW'(1);
                idle_q <= '0;
              end
            end else begin
              idle_q <= idle_inc;
              if (len_q != '0 && idle_inc >= timeout_q) begin
                len_q  <= '0;
                flen_q <= len_q;
                din_q  <= digital_inputs_i;
                scan_q <= scan_count_i;
                cnt_q  <= '0;
                crc_q  <= CRC_INIT;
                if (len_q >= CW'(4)) state_q <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q != '0) begin
            if (j < flen_q - CW'(2)) crc_q <= crc_next_walk;
            for (int i = 0; i < 6; i++) begin
              if (j == CW'(i)) hdr_q[i] <= rbyte;
            end
            if (j == flen_q - CW'(2)) fcs_lo_q <= rbyte;
            if (j == flen_q - CW'(1)) fcs_hi_q <= rbyte;
            if (cnt_q == walk_n) state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (frame_ok) begin
            for (int i = 0; i < 7; i++) rb_q[i] <= bd[i];
            n_q     <= bn;
            k_q     <= '0;
            coil_q  <= coil_d;
            crc_q   <= CRC_INIT;
            state_q <= ST_CRC;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_CRC: begin
          if (k_q == n_q) begin
            rb_q[n_q]         <= crc_q[7:0];
            rb_q[n_q + 4'd1]  <= crc_q[15:8];
            n_q               <= n_q + 4'd2;
            k_q               <= '0;
            state_q           <= ST_EMIT;
          end else begin
            crc_q <= crc_next_body;
            k_q   <= k_q + 4'd1;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            k_q <= k_q + 4'd1;
            if (last_byte_o) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_EMIT);
  assign tx_byte_o      = rb_q[k_q];
  assign last_byte_o    = (k_q == n_q - 4'd1);
  assign coil_outputs_o = coil_q;

endmodule

// ----- src/mrs_checker.sv -----
// Port-level checks for the Modbus RTU slave engine, bound to its top level.
// No package dependencies.
module mrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       req_type_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] tx_byte_o,
  input logic       last_byte_o
);

  // No item is taken while a reply is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while reply pending");

  // A received byte never starts a reply.
  a_byte_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !req_type_i) |=> !out_valid_o)
    else $error("reply after byte item");

  // The final reply item closes the reply.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_byte_o) |=> !out_valid_o)
    else $error("reply continued after last byte");

  // A stalled reply item holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(tx_byte_o)))
    else $error("stalled reply item changed");

endmodule

bind modbus_rtu_slave_engine mrs_checker u_mrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .tx_byte_o   (tx_byte_o),
  .last_byte_o (last_byte_o)
);

// ----- sim/tb_modbus_rtu_slave_engine.sv -----
// Self-checking testbench for the Modbus RTU slave engine: random request frames,
// ticks and register settings, with every reply byte checked against a predictor.
// Depends on mrs_pkg and modbus_rtu_slave_engine.
`timescale 1ns / 100ps

module tb_modbus_rtu_slave_engine;
  import mrs_pkg::*;

  localparam int BUF_DEPTH = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic [3:0] coils;
  } reply_t;

  // Slave model and reply checker.
  class modbus_scoreboard;
    bit [7:0]  buffer [BUF_DEPTH];
    int        fill;
    bit [15:0] idle;
    bit [3:0]  coils;
    bit [7:0]  station;
    bit [15:0] timeout;
    reply_t    pending [$];
    int        errors;
    int        checked;

    function new();
      foreach (buffer[i]) buffer[i] = 8'h00;
      fill = 0;
      idle = 0;
      coils = 0;
      station = 8'd1;
      timeout = 16'd5;
      errors = 0;
      checked = 0;
    endfunction

    function bit [15:0] crc16(bit [7:0] data [$]);
      bit [15:0] c;
      c = 16'hFFFF;
      foreach (data[i]) begin
        c ^= {8'h00, data[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    // Append the CRC and queue the reply bytes.
    function void emit(bit [7:0] body [$]);
      bit [15:0] c;
      reply_t r;
      c = crc16(body);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      foreach (body[i]) begin
        r.tx = body[i];
        r.last = (i == body.size() - 1);
        r.coils = coils;
        pending.push_back(r);
      end
    endfunction

    function void emit_exception(bit [7:0] fc, bit [7:0] code);
      bit [7:0] body [$];
      body = '{station, fc | EXC_FLAG, code};
      emit(body);
    endfunction

    // Decode an ended frame and predict the reply.
    function void handle_frame(int len, bit [3:0] din, bit [31:0] scan);
      bit [7:0]  fc;
      int        a;
      int        q;
      bit [7:0]  bits;
      bit [15:0] w;
      bit [7:0]  hdr [$];
      bit [7:0]  body [$];
      if (len < 4 || buffer[0] != station) return;
      for (int i = 0; i < len - 2; i++) hdr.push_back(buffer[i]);
      if ({buffer[len-1], buffer[len-2]} != crc16(hdr)) return;
      fc = buffer[1];
      a = int'({buffer[2], buffer[3]});
      q = int'({buffer[4], buffer[5]});
      body = '{station, fc};
      if (fc == FC_RD_COILS) begin
        if (q == 0 || q > 8 || a + q > 8) begin
          emit_exception(fc, EXC_ADDRESS);
        end else begin
          bits = 0;
          for (int i = 0; i < q; i++)
            bits[i] = (a + i < 4) ? coils[a+i] : din[a+i-4];
          body.push_back(8'd1);
          body.push_back(bits);
          emit(body);
        end
      end else if (fc == FC_WRITE_COIL) begin
        if (a > 3) emit_exception(fc, EXC_ADDRESS);
        else if (q != COIL_ON && q != COIL_CLEAR) emit_exception(fc, EXC_VALUE);
        else begin
          coils[a] = (q == COIL_ON);
          for (int i = 2; i < 6; i++) body.push_back(buffer[i]);
          emit(body);
        end
      end else if (fc == FC_READ_REGS) begin
        if (q == 0 || q > 2 || a + q > 2) begin
          emit_exception(fc, EXC_ADDRESS);
        end else begin
          body.push_back(8'(q * 2));
          for (int i = 0; i < q; i++) begin
            w = (a + i == 0) ? scan[15:0] : scan[31:16];
            body.push_back(w[15:8]);
            body.push_back(w[7:0]);
          end
          emit(body);
        end
      end else begin
        emit_exception(fc, EXC_FUNCTION);
      end
    endfunction

    function void note_item(bit rt, bit [7:0] b, bit [3:0] din, bit [31:0] scan);
      int len;
      if (rt == REQ_BYTE) begin
        if (fill < BUF_DEPTH) begin
          buffer[fill] = b;
          fill++;
          idle = 0;
        end
      end else begin
        if (idle != 16'hFFFF) idle++;
        if (fill != 0 && idle >= timeout) begin
          len = fill;
          fill = 0;
          handle_frame(len, din, scan);
        end
      end
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_reply(logic [7:0] tx, logic last, logic [3:0] co);
      reply_t e;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected reply byte %02h", tx));
        return;
      end
      e = pending.pop_front();
      if (tx !== e.tx) report($sformatf("tx_byte %02h, predicted %02h", tx, e.tx));
      if (last !== e.last) report($sformatf("last_byte %0b, predicted %0b", last, e.last));
      if (co !== e.coils) report($sformatf("coil_outputs %h, predicted %h", co, e.coils));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  rx_byte_i;
  logic [3:0]  digital_inputs_i;
  logic [31:0] scan_count_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  tx_byte_o;
  logic        last_byte_o;
  logic [3:0]  coil_outputs_o;

  modbus_rtu_slave_engine #(.BUFFER_DEPTH(BUF_DEPTH)) uut (.*);

  modbus_scoreboard sb = new();
  int  cycles = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_modbus_rtu_slave_engine: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts on out_ready_i.
  always @(negedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Each accepted reply byte is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(tx_byte_o, last_byte_o, coil_outputs_o);
  end

  // Drive one item and wait for it to be taken; entered and left at a falling edge.
  task automatic send_item(bit rt, bit [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = rt;
    rx_byte_i = b;
    digital_inputs_i = 4'($urandom);
    scan_count_i = $urandom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(rt, b, digital_inputs_i, scan_count_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(bit [7:0] f [$], int ticks);
    foreach (f[i]) send_item(REQ_BYTE, f[i]);
    repeat (ticks) send_item(REQ_TICK, 8'($urandom));
  endtask

  // Wait until every reply has come and the block has gone quiet.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, bit [15:0] v);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    if (idx == CFG_SLAVE_ADDRESS) sb.station = v[7:0];
    else sb.timeout = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic void add_crc(ref bit [7:0] f [$]);
    bit [15:0] c;
    c = sb.crc16(f);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
  endfunction

  // Mostly well-formed requests with random content; some noise and broken frames.
  function automatic void make_frame(output bit [7:0] f [$]);
    int sel;
    bit [7:0] st;
    bit [7:0] fc;
    bit [15:0] a;
    bit [15:0] q;
    f = {};
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      repeat ($urandom_range(1, 5)) f.push_back(8'($urandom));
      return;
    end
    if (sel < 7) begin
      f.push_back(sb.station);
      repeat ($urandom_range(60, 75)) f.push_back(8'($urandom));
      return;
    end
    st = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.station;
    case ($urandom_range(0, 3))
      0: begin
        fc = FC_RD_COILS;
        a = 16'($urandom_range(0, 8));
        q = 16'($urandom_range(0, 9));
      end
      1: begin
        fc = FC_READ_REGS;
        a = 16'($urandom_range(0, 2));
        q = 16'($urandom_range(0, 3));
      end
      2: begin
        fc = FC_WRITE_COIL;
        a = 16'($urandom_range(0, 4));
        if ($urandom_range(0, 5) == 0) q = 16'($urandom);
        else q = $urandom_range(0, 1) ? COIL_ON : COIL_CLEAR;
      end
      default: begin fc = 8'($urandom); a = 16'($urandom); q = 16'($urandom); end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      a = 16'($urandom);
      q = 16'($urandom);
    end
    f = '{st, fc, a[15:8], a[7:0], q[15:8], q[7:0]};
    if ($urandom_range(0, 14) == 0) f = f[0:$urandom_range(0, 3)];
    add_crc(f);
    if ($urandom_range(0, 9) == 0)
      f[$urandom_range(0, f.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  task automatic random_phase(int frames);
    bit [7:0] f [$];
    repeat (frames) begin
      make_frame(f);
      send_frame(f, sb.timeout + $urandom_range(0, 2));
      if (!quiet && $urandom_range(0, 15) == 0) drain();
    end
  endtask

  initial begin
    bit [7:0] f [$];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_SLAVE_ADDRESS;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_BYTE;
    rx_byte_i = '0;
    digital_inputs_i = '0;
    scan_count_i = '0;
    out_ready_i = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: lowest address, shortest timeout; write coil, read coils, read both words.
    write_reg(CFG_SLAVE_ADDRESS, 16'd1);
    write_reg(CFG_FRAME_TIMEOUT, 16'd1);
    f = '{8'd1, FC_WRITE_COIL, 8'h00, 8'h03, COIL_ON[15:8], COIL_ON[7:0]};
    add_crc(f);
    send_frame(f, 1);
    f = '{8'd1, FC_RD_COILS, 8'h00, 8'h00, 8'h00, 8'h08};
    add_crc(f);
    send_frame(f, 1);
    f = '{8'd1, FC_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h02};
    add_crc(f);
    send_frame(f, 1);
    drain();

    // Highest address.
    write_reg(CFG_SLAVE_ADDRESS, 16'd247);
    write_reg(CFG_FRAME_TIMEOUT, 16'd3);
    random_phase(10);
    drain();

    write_reg(CFG_SLAVE_ADDRESS, 16'($urandom_range(2, 246)));
    write_reg(CFG_FRAME_TIMEOUT, 16'($urandom_range(1, 6)));
    random_phase(7);
    drain();

    // Longer timeout: the frame ends only after a long run of idle ticks.
    quiet = 1'b1;
    write_reg(CFG_FRAME_TIMEOUT, 16'd20);
    f = '{sb.station, FC_READ_REGS, 8'h00, 8'h01, 8'h00, 8'h01};
    add_crc(f);
    send_frame(f, 20);
    drain();

    // Final stretch with no idling on either side.
    write_reg(CFG_SLAVE_ADDRESS, 16'd1);
    write_reg(CFG_FRAME_TIMEOUT, 16'd2);
    random_phase(7);
    drain();

    $display("Sent %0d items over five register settings, a longer timeout included;",
             items_sent);
    $display("checked %0d reply bytes, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_modbus_rtu_slave_engine: clean");
    end else begin
      $display("tb_modbus_rtu_slave_engine: errors");
    end
    $finish;
  end

endmodule
